// File: rtl/palette_fade_engine_macros.svh
// Assertion macros shared by the palette fade engine RTL.
`ifndef PALETTE_FADE_ENGINE_MACROS_SVH
`define PALETTE_FADE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pfe_pkg.sv
// Types and constants of the palette fade engine.
`default_nettype none

package pfe_pkg;

  // Fixed-point format and run limits
  localparam int FRAC_BITS = 7;
  localparam int CHAN_W    = 8;
  localparam int ACC_W     = 16;
  localparam int DIV_W     = CHAN_W + FRAC_BITS;   // dividend magnitude bits
  localparam int STEP_W    = 12;                   // divisor / countdown bits
  localparam int MAX_RUN   = 64;
  localparam int IDX_W     = 6;                    // index into a run
  localparam int RUN_W     = 7;                    // run length, 0..MAX_RUN
  localparam int NUM_CHAN  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ARM  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ENTRY  = 3'd0,
    CFG_ENTRY_COUNT  = 3'd1,
    CFG_STEP_COUNT   = 3'd2,
    CFG_TARGET_RED   = 3'd3,
    CFG_TARGET_GREEN = 3'd4,
    CFG_TARGET_BLUE  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DATA,
    ST_DIV,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] tag;
  } pal_entry_t;

  // Per run position: Q8.7 accumulators and signed increments, red first
  typedef struct packed {
    logic [NUM_CHAN-1:0][ACC_W-1:0] accum;
    logic [NUM_CHAN-1:0][ACC_W-1:0] step;
  } fade_word_t;

endpackage

`default_nettype wire

// File: rtl/pfe_div.sv
// Three-lane restoring divider for the fade increments, one quotient bit per cycle.
`default_nettype none
`include "palette_fade_engine_macros.svh"

module pfe_div import pfe_pkg::*; (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [STEP_W-1:0]                  divisor_i,
  input  wire logic [NUM_CHAN-1:0][DIV_W-1:0]     dividend_i,
  input  wire logic [NUM_CHAN-1:0]                neg_i,
  output logic                                    done_o,
  output logic [NUM_CHAN-1:0][ACC_W-1:0]          quot_o
);

  localparam logic [3:0] LAST_CNT = 4'(DIV_W - 1);

  logic                             busy_q, fin_q;
  logic [3:0]                       cnt_q;
  logic [STEP_W-1:0]                dvs_q;
  logic [NUM_CHAN-1:0]              neg_q;
  logic [NUM_CHAN-1:0][STEP_W-1:0]  rem_q, rem_d;
  logic [NUM_CHAN-1:0][DIV_W-1:0]   quo_q, quo_d;

  // One restoring step per lane
  always_comb begin
    logic [STEP_W:0] shifted;
    logic [STEP_W:0] diff;
    logic            ge;
    for (int l = 0; l < NUM_CHAN; l++) begin
      shifted  = {rem_q[l], quo_q[l][DIV_W-1]};
      diff     = shifted - {1'b0, dvs_q};
      ge       = (shifted >= {1'b0, dvs_q});
      rem_d[l] = ge ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
      quo_d[l] = {quo_q[l][DIV_W-2:0], ge};
    end
  end

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= busy_q && (cnt_q == LAST_CNT);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST_CNT) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
    end
  end

  // Operand and partial-result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      neg_q <= neg_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Apply the sign: truncation toward zero
  always_comb begin
    logic [ACC_W-1:0] mag;
    for (int l = 0; l < NUM_CHAN; l++) begin
      mag       = {{(ACC_W-DIV_W){1'b0}}, quo_q[l]};
      quot_o[l] = neg_q[l] ? (~mag + {{(ACC_W-1){1'b0}}, 1'b1}) : mag;
    end
  end

  assign done_o = fin_q;

  `PFE_ASSERT_IMP(a_div_no_restart, start_i, !busy_q && !fin_q, "divider restarted while busy")
  `PFE_ASSERT_NXT(a_div_finish, busy_q && (cnt_q == LAST_CNT), fin_q && !busy_q,
                  "divider did not finish after its last step")

endmodule

`default_nettype wire

// File: rtl/pfe_pal_mem.sv
// Palette memory: one write and one registered read port, per-entry valid bits.
`default_nettype none
`include "palette_fade_engine_macros.svh"

module pfe_pal_mem import pfe_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire pal_entry_t    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output pal_entry_t         rd_data_o
);

  pal_entry_t             mem [DEPTH];
  pal_entry_t             rd_q;
  logic       [DEPTH-1:0] vld_q;
  logic                   rd_vld_q;

  // Mark written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

  `PFE_ASSERT_IMP(a_pal_no_collide, rd_en_i && wr_en_i, rd_addr_i != wr_addr_i,
                  "palette read and write hit the same entry")

endmodule

`default_nettype wire

// File: rtl/palette_fade_engine.sv
// Palette fade engine top level: command sequencer, fade memory and result register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid_i/in_ready_o | cmd, entry_addr, load_red/green/blue/tag
//   out     | output    | out_valid_o/out_ready_i | out_addr, out_red/green/blue, out_tag,
//           |           |                       | ticks_left, last
//   cfg     | input     | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// Load, arm, idle ticks and unused commands are handled in idle. A tick over a run of n entries
// steps each entry through palette/fade memory read, data and result, adding a divide state per
// entry on the first tick of a fade for the 15-bit serial divide of the three increments.
// Reset clears control and marks every palette entry unwritten, so it reads as zero; there
// is no clearing pass. A stalled result holds the sequencer in its result state; a new
// transaction is taken as soon as the sequencer is back in idle, even with a result pending.
`default_nettype none

module palette_fade_engine import pfe_pkg::*; #(
  parameter int PALETTE_DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // commands
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [5:0]           entry_addr_i,
  input  wire logic [7:0]           load_red_i,
  input  wire logic [7:0]           load_green_i,
  input  wire logic [7:0]           load_blue_i,
  input  wire logic [7:0]           load_tag_i,
  // faded colors
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [5:0]                out_addr_o,
  output logic [7:0]                out_red_o,
  output logic [7:0]                out_green_o,
  output logic [7:0]                out_blue_o,
  output logic [7:0]                out_tag_o,
  output logic [11:0]               ticks_left_o,
  output logic                      last_o
);

`include "palette_fade_engine_macros.svh"

  localparam int         AW        = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_W   = 9'(PALETTE_DEPTH);
  localparam logic [8:0] MAX_RUN_W = 9'(MAX_RUN);

  // Configuration registers
  logic [5:0]                       first_q;
  logic [6:0]                       count_q;
  logic [STEP_W-1:0]                step_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0]  tgt_q;

  // Sequencer state
  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] countdown_q, left_q;
  logic [IDX_W-1:0]  idx_q;
  logic [RUN_W-1:0]  run_q;
  logic              first_tick_q, final_tick_q;

  // Working values of the current entry
  logic [NUM_CHAN-1:0][ACC_W-1:0] cur_q, stp_q;

  // Result register
  logic              out_valid_q;
  logic [5:0]        out_addr_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] out_rgb_q;
  logic [7:0]        out_tag_q;
  logic [STEP_W-1:0] out_left_q;
  logic              out_last_q;

  // Fade memory
  fade_word_t fade_mem [MAX_RUN];
  fade_word_t fade_rd_q;
  fade_word_t fade_wr;

  // Combinational control
  cmd_e              cmd;
  logic              in_acc, emit, rd_en, div_start, last_d;
  logic [STEP_W-1:0] step_eff;
  logic [8:0]        first_ext, avail, run_full, entry_sum, load_ext;
  logic [RUN_W-1:0]  run_len;
  logic              tick_go, load_ok;

  // Palette port signals
  logic                             pal_wr_en;
  logic [AW-1:0]                    pal_wr_addr, pal_rd_addr;
  pal_entry_t                       pal_wr_data, pal_rd;
  logic [NUM_CHAN-1:0][CHAN_W-1:0]  pal_chan;

  // Divider signals
  logic                             div_done;
  logic [NUM_CHAN-1:0][DIV_W-1:0]   div_dividend;
  logic [NUM_CHAN-1:0]              div_neg;
  logic [NUM_CHAN-1:0][ACC_W-1:0]   div_quot;

  // Result values of the current entry
  logic [NUM_CHAN-1:0][ACC_W-1:0]   acc_sum;
  logic [NUM_CHAN-1:0][CHAN_W-1:0]  rgb_d;

  assign cmd      = cmd_e'(cmd_i);
  assign in_acc   = in_valid_i && in_ready_o;
  assign step_eff = (step_q == '0) ? {{(STEP_W-1){1'b0}}, 1'b1} : step_q;

  // Clip the run to the palette end and the run limit
  always_comb begin
    first_ext = {3'b000, first_q};
    avail     = DEPTH_W - first_ext;
    if (first_ext >= DEPTH_W) begin
      run_full = '0;
    end else begin
      run_full = {2'b00, count_q};
      if (run_full > avail) begin
        run_full = avail;
      end
      if (run_full > MAX_RUN_W) begin
        run_full = MAX_RUN_W;
      end
    end
    run_len = run_full[RUN_W-1:0];
  end

  assign entry_sum = first_ext + {3'b000, idx_q};
  assign load_ext  = {3'b000, entry_addr_i};
  assign load_ok   = (load_ext < DEPTH_W);
  assign tick_go   = (cmd == CMD_TICK) && (countdown_q != '0);
  assign last_d    = ({1'b0, idx_q} + {{(RUN_W-1){1'b0}}, 1'b1}) == run_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && tick_go && (run_len != '0)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_DATA;
      ST_DATA: state_d = first_tick_q ? ST_DIV : ST_OUT;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (emit) begin
          state_d = last_d ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_READ: rd_en      = 1'b1;
      ST_DATA: div_start  = first_tick_q;
      ST_DIV:  ;
      ST_OUT:  emit       = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Channel operands of the entry just read
  assign pal_chan[0] = pal_rd.red;
  assign pal_chan[1] = pal_rd.green;
  assign pal_chan[2] = pal_rd.blue;

  always_comb begin
    logic [CHAN_W-1:0] absd;
    for (int c = 0; c < NUM_CHAN; c++) begin
      div_neg[c]      = tgt_q[c] < pal_chan[c];
      absd            = div_neg[c] ? (pal_chan[c] - tgt_q[c]) : (tgt_q[c] - pal_chan[c]);
      div_dividend[c] = {absd, {FRAC_BITS{1'b0}}};
    end
  end

  // Advance the accumulators, or snap to the target on the final tick
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc_sum[c]       = cur_q[c] + stp_q[c];
      rgb_d[c]         = final_tick_q ? tgt_q[c] : acc_sum[c][FRAC_BITS +: CHAN_W];
      fade_wr.accum[c] = final_tick_q ? cur_q[c] : acc_sum[c];
      fade_wr.step[c]  = stp_q[c];
    end
  end

  // Palette write: loads in idle, target write-back on the final tick
  always_comb begin
    pal_rd_addr = AW'(entry_sum);
    if (state_q == ST_IDLE) begin
      pal_wr_en   = in_acc && (cmd == CMD_LOAD) && load_ok;
      pal_wr_addr = AW'(load_ext);
      pal_wr_data = '{red: load_red_i, green: load_green_i, blue: load_blue_i,
                      tag: load_tag_i};
    end else begin
      pal_wr_en   = emit && final_tick_q;
      pal_wr_addr = AW'(entry_sum);
      pal_wr_data = '{red: tgt_q[0], green: tgt_q[1], blue: tgt_q[2], tag: pal_rd.tag};
    end
  end

  pfe_pal_mem #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_pal_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (pal_wr_en),
    .wr_addr_i (pal_wr_addr),
    .wr_data_i (pal_wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (pal_rd_addr),
    .rd_data_o (pal_rd)
  );

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (step_eff),
    .dividend_i (div_dividend),
    .neg_i      (div_neg),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Fade memory: read in the read state, write back with each result
  always_ff @(posedge clk_i) begin
    if (emit) begin
      fade_mem[idx_q] <= fade_wr;
    end
    if (rd_en) begin
      fade_rd_q <= fade_mem[idx_q];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_q      <= '0;
      count_q      <= '0;
      step_q       <= {{(STEP_W-1){1'b0}}, 1'b1};
      tgt_q        <= '0;
      countdown_q  <= '0;
      idx_q        <= '0;
      run_q        <= '0;
      first_tick_q <= 1'b0;
      final_tick_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // Write a configuration register
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FIRST_ENTRY:  first_q  <= cfg_data_i[5:0];
          CFG_ENTRY_COUNT:  count_q  <= cfg_data_i[6:0];
          CFG_STEP_COUNT:   step_q   <= cfg_data_i;
          CFG_TARGET_RED:   tgt_q[0] <= cfg_data_i[7:0];
          CFG_TARGET_GREEN: tgt_q[1] <= cfg_data_i[7:0];
          CFG_TARGET_BLUE:  tgt_q[2] <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      // Take a command
      if (in_acc) begin
        if (cmd == CMD_ARM) begin
          countdown_q <= step_eff;
        end else if (tick_go) begin
          countdown_q  <= countdown_q - {{(STEP_W-1){1'b0}}, 1'b1};
          first_tick_q <= (countdown_q == step_eff);
          final_tick_q <= (countdown_q == {{(STEP_W-1){1'b0}}, 1'b1});
          run_q        <= run_len;
          idx_q        <= '0;
        end
      end

      // Step to the next entry of the run
      if (emit && !last_d) begin
        idx_q <= idx_q + {{(IDX_W-1){1'b0}}, 1'b1};
      end

      // Hold the result until taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && tick_go) begin
      left_q <= countdown_q - {{(STEP_W-1){1'b0}}, 1'b1};
    end
    if (state_q == ST_DATA) begin
      if (first_tick_q) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          cur_q[c] <= {1'b0, pal_chan[c], {FRAC_BITS{1'b0}}};
        end
      end else begin
        cur_q <= fade_rd_q.accum;
        stp_q <= fade_rd_q.step;
      end
    end
    if ((state_q == ST_DIV) && div_done) begin
      stp_q <= div_quot;
    end
    if (emit) begin
      out_addr_q <= entry_sum[5:0];
      out_rgb_q  <= rgb_d;
      out_tag_q  <= pal_rd.tag;
      out_left_q <= left_q;
      out_last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_red_o    = out_rgb_q[0];
  assign out_green_o  = out_rgb_q[1];
  assign out_blue_o   = out_rgb_q[2];
  assign out_tag_o    = out_tag_q;
  assign ticks_left_o = out_left_q;
  assign last_o       = out_last_q;

  `PFE_ASSERT_IMP(a_idx_in_run, state_q != ST_IDLE, {1'b0, idx_q} < run_q,
                  "run index beyond run length")
  `PFE_ASSERT_NXT(a_run_end, emit && last_d, state_q == ST_IDLE,
                  "sequencer not idle after last result of a run")
  `PFE_ASSERT_IMP(a_div_only_first, div_start, first_tick_q && (state_q == ST_DATA),
                  "divide started outside the first tick")

endmodule

`default_nettype wire

// File: dv/palette_fade_engine_tb.sv
// Self-checking testbench for the palette fade engine: loads, arms and fade ticks.
module palette_fade_engine_tb import pfe_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PAL_DEPTH   = 64;
  localparam int unsigned STALL_LIMIT = 6000;  // cycles without any transaction
  localparam int unsigned SETTLE      = 8;     // cycles for a no-result command
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] addr;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] tag;
  } cmd_item_t;

  typedef struct packed {
    logic [5:0]  addr;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  tag;
    logic [11:0] left;
    logic        last;
  } fade_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  cfg_idx_e          cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        cmd_i;
  logic [5:0]        entry_addr_i;
  logic [7:0]        load_red_i;
  logic [7:0]        load_green_i;
  logic [7:0]        load_blue_i;
  logic [7:0]        load_tag_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [5:0]        out_addr_o;
  logic [7:0]        out_red_o;
  logic [7:0]        out_green_o;
  logic [7:0]        out_blue_o;
  logic [7:0]        out_tag_o;
  logic [11:0]       ticks_left_o;
  logic              last_o;

  // Mirror of the block state and its registers
  pal_entry_t        pal_mirror [PAL_DEPTH];
  logic [ACC_W-1:0]  fade_acc [NUM_CHAN*MAX_RUN];
  logic [ACC_W-1:0]  fade_inc [NUM_CHAN*MAX_RUN];
  logic [11:0]       countdown_m;
  logic [5:0]        cf_first;
  logic [6:0]        cf_count;
  logic [11:0]       cf_steps;
  logic [7:0]        cf_target [NUM_CHAN];

  // Stimulus-side view: countdown and run positions whose increments exist
  logic [11:0]       plan_countdown;
  logic [63:0]       plan_filled;

  cmd_item_t         pending_cmds [$];
  fade_result_t      expected_colors [$];
  int                cmds_outstanding = 0;
  int unsigned       errors = 0;
  int unsigned       idle_cycles = 0;
  bit                in_fire_q = 1'b0;
  int unsigned       burst_left = 1;
  int unsigned       gap_left = 0;
  logic [15:0]       stall_pat = '1;
  int unsigned       stall_age = 0;

  palette_fade_engine #(.PALETTE_DEPTH(PAL_DEPTH)) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .entry_addr_i (entry_addr_i),
    .load_red_i   (load_red_i),
    .load_green_i (load_green_i),
    .load_blue_i  (load_blue_i),
    .load_tag_i   (load_tag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_addr_o   (out_addr_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_tag_o    (out_tag_o),
    .ticks_left_o (ticks_left_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned fade_steps();
    return (cf_steps == 0) ? 1 : cf_steps;
  endfunction

  // Entries in the faded range, clipped to the palette end and the run limit
  function automatic int unsigned fade_span();
    int unsigned n;
    n = cf_count;
    if (n > PAL_DEPTH - cf_first) n = PAL_DEPTH - cf_first;
    if (n > MAX_RUN) n = MAX_RUN;
    return n;
  endfunction

  function automatic logic [7:0] chan_of(pal_entry_t e, int c);
    case (c)
      0:       return e.red;
      1:       return e.green;
      default: return e.blue;
    endcase
  endfunction

  // Update the mirror for one accepted command and queue the colors it emits
  function automatic void compute_fade(cmd_item_t it);
    int unsigned steps, n, addr, k;
    int          cur, quo;
    logic [15:0] sum;
    logic [7:0]  rgb [NUM_CHAN];
    logic [11:0] left;
    bit          final_tick;
    pal_entry_t  e;
    case (it.cmd)
      CMD_LOAD: begin
        pal_mirror[it.addr] = '{red: it.red, green: it.green, blue: it.blue, tag: it.tag};
      end
      CMD_ARM: begin
        countdown_m = 12'(fade_steps());
      end
      CMD_TICK: begin
        if (countdown_m != 0) begin
          steps = fade_steps();
          n = fade_span();
          // first tick of a fade: start values and truncated increments
          if (countdown_m == steps) begin
            for (int i = 0; i < n; i++) begin
              e = pal_mirror[cf_first + i];
              for (int c = 0; c < NUM_CHAN; c++) begin
                cur = int'(chan_of(e, c)) << FRAC_BITS;
                quo = ((int'(cf_target[c]) << FRAC_BITS) - cur) / int'(steps);
                fade_acc[NUM_CHAN*i + c] = cur[15:0];
                fade_inc[NUM_CHAN*i + c] = quo[15:0];
              end
            end
          end
          final_tick = (countdown_m == 1);
          left = countdown_m - 12'd1;
          for (int i = 0; i < n; i++) begin
            addr = cf_first + i;
            e = pal_mirror[addr];
            for (int c = 0; c < NUM_CHAN; c++) begin
              if (final_tick) begin
                rgb[c] = cf_target[c];
              end else begin
                k = NUM_CHAN*i + c;
                sum = fade_acc[k] + fade_inc[k];
                fade_acc[k] = sum;
                rgb[c] = sum[FRAC_BITS +: CHAN_W];
              end
            end
            if (final_tick) begin
              pal_mirror[addr] = '{red: rgb[0], green: rgb[1], blue: rgb[2], tag: e.tag};
            end
            expected_colors.push_back('{addr: 6'(addr), red: rgb[0], green: rgb[1],
                                        blue: rgb[2], tag: e.tag, left: left,
                                        last: (i == n - 1)});
          end
          countdown_m = left;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one command; a tick that would run on increments never computed becomes an arm.
  // Returns 1 when the block does real work on it.
  function automatic bit push_cmd(logic [1:0] cmd, logic [5:0] addr, logic [7:0] red,
                                  logic [7:0] green, logic [7:0] blue, logic [7:0] tag);
    logic [63:0] need;
    int unsigned n;
    bit          counts;
    n = fade_span();
    need = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    if (cmd == CMD_TICK && plan_countdown > 1 && plan_countdown != fade_steps() &&
        (plan_filled & need) != need) begin
      cmd = CMD_ARM;
    end
    counts = 1'b1;
    case (cmd)
      CMD_LOAD: ;
      CMD_ARM:  plan_countdown = 12'(fade_steps());
      CMD_TICK: begin
        if (plan_countdown == 0) begin
          counts = 1'b0;
        end else begin
          if (plan_countdown == fade_steps()) plan_filled |= need;
          plan_countdown--;
        end
      end
      default:  counts = 1'b0;
    endcase
    pending_cmds.push_back('{cmd: cmd, addr: addr, red: red, green: green, blue: blue,
                             tag: tag});
    cmds_outstanding++;
    return counts;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic set_fade_regs(logic [5:0] first, logic [6:0] cnt, logic [11:0] steps,
                               logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    write_reg(CFG_FIRST_ENTRY, CFG_W'(first));
    write_reg(CFG_ENTRY_COUNT, CFG_W'(cnt));
    write_reg(CFG_STEP_COUNT, steps);
    write_reg(CFG_TARGET_RED, CFG_W'(red));
    write_reg(CFG_TARGET_GREEN, CFG_W'(green));
    write_reg(CFG_TARGET_BLUE, CFG_W'(blue));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold until every command is taken and every color has come, then wait extra cycles
  task automatic wait_drained(int unsigned extra);
    do @(negedge clk_i);
    while (cmds_outstanding != 0 || expected_colors.size() != 0);
    @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Mostly well-formed fades (loads, arm, ticks) with random noise commands mixed in
  task automatic random_phase(int unsigned n_items, bit pause_midway);
    int unsigned done_items, n, k;
    bit          paused;
    done_items = 0;
    paused = 1'b0;
    while (done_items < n_items) begin
      if (pause_midway && !paused && done_items >= n_items / 2) begin
        paused = 1'b1;
        wait_drained(0);
      end
      n = fade_span();
      if ($urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(0, 3)) begin
          done_items += push_cmd(CMD_LOAD,
                                 (n == 0) ? 6'($urandom) : 6'(cf_first + $urandom_range(0, n - 1)),
                                 rand_chan(), rand_chan(), rand_chan(), 8'($urandom));
        end
        done_items += push_cmd(CMD_ARM, 6'($urandom), rand_chan(), rand_chan(), rand_chan(),
                               8'($urandom));
        k = (fade_steps() < 6) ? fade_steps() : 6;
        repeat ($urandom_range(1, k + 1)) begin
          done_items += push_cmd(CMD_TICK, 6'($urandom), rand_chan(), rand_chan(),
                                 rand_chan(), 8'($urandom));
        end
      end else begin
        done_items += push_cmd(2'($urandom), 6'($urandom), rand_chan(), rand_chan(),
                               rand_chan(), 8'($urandom));
      end
    end
  endtask

  // Drive command transactions in bursts with random gaps
  always @(negedge clk_i) begin : drive_cmds
    cmd_item_t nxt;
    if (rst_ni && (!in_valid_i || in_fire_q)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        in_valid_i   <= 1'b1;
        cmd_i        <= nxt.cmd;
        entry_addr_i <= nxt.addr;
        load_red_i   <= nxt.red;
        load_green_i <= nxt.green;
        load_blue_i  <= nxt.blue;
        load_tag_i   <= nxt.tag;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          if ($urandom_range(0, 2) == 0) gap_left = 0;
          else if ($urandom_range(0, 7) == 0) gap_left = 25;
          else gap_left = $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result channel on a rotating pattern that changes now and then
  always @(negedge clk_i) begin
    if (stall_age == 0) begin
      stall_age = $urandom_range(40, 120);
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = 16'($urandom);
        2:       stall_pat = 16'($urandom) & 16'($urandom);
        default: stall_pat = 16'($urandom) | 16'($urandom);
      endcase
      stall_pat[$urandom_range(0, 15)] = 1'b1;
    end
    stall_age--;
    out_ready_i <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  // Track register writes, check colors, predict from accepted commands, watch for hangs
  always @(posedge clk_i) begin : observe
    fade_result_t want;
    cmd_item_t    got_cmd;
    bit           out_fire;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIRST_ENTRY:  cf_first     = cfg_data_i[5:0];
          CFG_ENTRY_COUNT:  cf_count     = cfg_data_i[6:0];
          CFG_STEP_COUNT:   cf_steps     = cfg_data_i[11:0];
          CFG_TARGET_RED:   cf_target[0] = cfg_data_i[7:0];
          CFG_TARGET_GREEN: cf_target[1] = cfg_data_i[7:0];
          CFG_TARGET_BLUE:  cf_target[2] = cfg_data_i[7:0];
          default: ;
        endcase
      end

      // compare the result transaction with the oldest expected color
      out_fire = out_valid_o && out_ready_i;
      if (out_fire) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected result transaction: out_addr 0x%0h", out_addr_o);
          errors++;
        end else begin
          want = expected_colors.pop_front();
          check_field("out_addr", 12'(want.addr), 12'(out_addr_o));
          check_field("out_red", 12'(want.red), 12'(out_red_o));
          check_field("out_green", 12'(want.green), 12'(out_green_o));
          check_field("out_blue", 12'(want.blue), 12'(out_blue_o));
          check_field("out_tag", 12'(want.tag), 12'(out_tag_o));
          check_field("ticks_left", want.left, ticks_left_o);
          check_field("last", 12'(want.last), 12'(last_o));
        end
      end

      in_fire_q = in_valid_i && in_ready_o;
      if (in_fire_q) begin
        got_cmd = '{cmd: cmd_i, addr: entry_addr_i, red: load_red_i, green: load_green_i,
                    blue: load_blue_i, tag: load_tag_i};
        compute_fade(got_cmd);
        cmds_outstanding--;
      end

      if (in_fire_q || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [5:0]  rf;
    logic [6:0]  rc;
    logic [11:0] rs;
    int unsigned pick;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_FIRST_ENTRY;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_LOAD;
    entry_addr_i = '0;
    load_red_i   = '0;
    load_green_i = '0;
    load_blue_i  = '0;
    load_tag_i   = '0;
    out_ready_i  = 1'b0;
    foreach (pal_mirror[i]) pal_mirror[i] = '0;
    countdown_m    = '0;
    cf_first       = '0;
    cf_count       = '0;
    cf_steps       = 12'd1;
    cf_target[0]   = '0;
    cf_target[1]   = '0;
    cf_target[2]   = '0;
    plan_countdown = '0;
    plan_filled    = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty range: idle tick, unused command, arm, counting tick, extreme loads
    set_fade_regs(6'd0, 7'd0, 12'd1, 8'h00, 8'h00, 8'h00);
    void'(push_cmd(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    void'(push_cmd(CMD_UNUSED, 6'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    void'(push_cmd(CMD_ARM, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    void'(push_cmd(CMD_TICK, 6'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    void'(push_cmd(CMD_LOAD, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    void'(push_cmd(CMD_LOAD, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    void'(push_cmd(CMD_LOAD, 6'd1, 8'hFF, 8'h00, 8'h80, 8'hA5));
    void'(push_cmd(CMD_LOAD, 6'd62, 8'h01, 8'hFE, 8'h7F, 8'h5A));
    wait_drained(SETTLE);

    // Zero step count acts as one: the first tick is also the final one
    set_fade_regs(6'd0, 7'd2, 12'd0, 8'hFF, 8'h00, 8'h80);
    void'(push_cmd(CMD_ARM, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    void'(push_cmd(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained(SETTLE);

    // Range clipped at the palette end, full three-tick fade, then an idle tick
    set_fade_regs(6'd62, 7'd64, 12'd3, 8'h00, 8'hFF, 8'h00);
    void'(push_cmd(CMD_ARM, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (4) void'(push_cmd(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained(SETTLE);

    // Whole palette with the longest fade; a load mid-fade changes only the tag
    set_fade_regs(6'd0, 7'd64, 12'd4095, 8'hFF, 8'hFF, 8'hFF);
    void'(push_cmd(CMD_LOAD, 6'd5, 8'h10, 8'hC0, 8'h33, 8'h77));
    void'(push_cmd(CMD_ARM, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    void'(push_cmd(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    void'(push_cmd(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    void'(push_cmd(CMD_LOAD, 6'd0, 8'h20, 8'h20, 8'h20, 8'hC3));
    void'(push_cmd(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained(SETTLE);

    // Step count changed mid-fade: keep old increments, then re-arm
    set_fade_regs(6'd0, 7'd3, 12'd2, 8'h40, 8'h00, 8'hFF);
    void'(push_cmd(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    void'(push_cmd(CMD_ARM, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (2) void'(push_cmd(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained(SETTLE);

    // Random settings, mostly short ranges and short fades
    for (int p = 0; p < 8; p++) begin
      if (p == 0) rf = 6'd63;
      else if ($urandom_range(0, 1) == 0) rf = 6'($urandom_range(0, 63));
      else rf = 6'($urandom_range(0, 8));
      pick = $urandom_range(0, 9);
      if (pick == 0) rc = 7'd0;
      else if (pick == 1) rc = 7'($urandom_range(7, 64));
      else rc = 7'($urandom_range(1, 6));
      pick = $urandom_range(0, 9);
      if (pick < 7) rs = 12'($urandom_range(0, 6));
      else if (pick < 9) rs = 12'($urandom_range(7, 40));
      else rs = 12'($urandom_range(41, 4095));
      set_fade_regs(rf, rc, rs, rand_chan(), rand_chan(), rand_chan());
      random_phase(22, p == 3);
      wait_drained(SETTLE);
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
